// ===== rtl/core/pcpa_pkg.sv =====
// shared types and codes for the per-cpu page allocator
// no dependencies
package pcpa_pkg;

  localparam int ADDR_W    = 56;
  localparam int IDX_MAX_W = 20;
  localparam int CPU_MAX_W = 6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic       REG_START = 1'b0;
  localparam logic       REG_TOP   = 1'b1;

  localparam logic       OP_FREE  = 1'b0;
  localparam logic       OP_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    K_FREE  = 2'd0,
    K_BAD   = 2'd1,
    K_ALLOC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CPU_MAX_W-1:0]   cpu;
    logic [IDX_MAX_W-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

// ===== rtl/core/pcpa_front.sv =====
// front end: config registers, command classification and a two-entry command queue
// depends on pcpa_pkg
module pcpa_front #(
  parameter int NUM_CPUS   = 8,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 32768
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [2:0]              in_cpu,
  input  logic [55:0]             in_page_addr,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [55:0]             cfg_data,
  output logic [55:0]             page_base,
  output pcpa_pkg::qhead_t        q_head,
  input  logic                    q_pop
);
  import pcpa_pkg::*;

  localparam int PB_LOG = $clog2(PAGE_BYTES);

  logic [55:0] start_r, top_r;
  logic [55:0] diff, diff_pg;
  logic [2:0]  cpu_w;
  logic        bad;
  cmd_t        cmd;
  cmd_t        q_mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 56'h0000_0080_000000;
      top_r   <= 56'h0000_0088_000000;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START) start_r <= cfg_data;
      else top_r <= cfg_data;
    end
  end

  // round region start up to a page boundary
  assign page_base = {start_r[55:PB_LOG] + (56-PB_LOG)'(|start_r[PB_LOG-1:0]),
                      {PB_LOG{1'b0}}};

  always_comb begin
    cpu_w = in_cpu;
    for (int i = 0; i < 8; i++) begin
      if ({29'd0, cpu_w} >= NUM_CPUS) cpu_w = 3'(32'(cpu_w) - NUM_CPUS);
    end
  end

  assign diff    = in_page_addr - page_base;
  assign diff_pg = diff >> PB_LOG;
  assign bad     = (|in_page_addr[PB_LOG-1:0]) || (in_page_addr < start_r) ||
                   (in_page_addr >= top_r) || (diff_pg >= 56'(MAX_PAGES));

  always_comb begin
    cmd.cpu = CPU_MAX_W'(cpu_w);
    cmd.idx = diff_pg[IDX_MAX_W-1:0];
    if (in_operation == OP_ALLOC) cmd.kind = K_ALLOC;
    else if (bad) cmd.kind = K_BAD;
    else cmd.kind = K_FREE;
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/pcpa_back.sv =====
// back end: free list heads, counts, link memory and the alloc / steal sequencer
// depends on pcpa_pkg
module pcpa_back #(
  parameter int NUM_CPUS    = 8,
  parameter int STEAL_LIMIT = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_PAGES   = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [55:0]        page_base,
  input  pcpa_pkg::qhead_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic [55:0]        out_page_addr_res,
  output logic [1:0]         out_status
);
  import pcpa_pkg::*;

  localparam int PB_LOG = $clog2(PAGE_BYTES);
  localparam int LW     = $clog2(MAX_PAGES);
  localparam int CW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int TW     = $clog2(STEAL_LIMIT + 2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_VIC  = 7'b0000100,
    S_WALK = 7'b0001000,
    S_WWB  = 7'b0010000,
    S_CUT  = 7'b0100000,
    S_CHK  = 7'b1000000
  } state_t;

  state_t        state_r;
  logic [LW-1:0] link_mem [MAX_PAGES];
  logic [LW-1:0] rdata_r;
  logic [LW-1:0] rd_addr, wr_addr, wr_data;
  logic          wr_en;
  logic [LW-1:0] heads_r  [NUM_CPUS];
  logic [31:0]   counts_r [NUM_CPUS];
  logic [CW-1:0] cpu_r, v_r, qcpu;
  logic [LW-1:0] h_r, r_r, qidx;
  logic [TW-1:0] taken_r, steps_r;
  logic          cont;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  assign qcpu  = q_head.cmd.cpu[CW-1:0];
  assign qidx  = q_head.cmd.idx[LW-1:0];
  assign q_pop = (state_r == S_IDLE) && q_head.valid;
  assign cont  = (32'(taken_r) < counts_r[v_r]) && (steps_r < TW'(STEAL_LIMIT));

  always_comb begin
    case (state_r)
      S_WALK:  rd_addr = r_r;
      S_IDLE:  rd_addr = heads_r[qcpu];
      default: rd_addr = heads_r[cpu_r];
    endcase
    wr_en   = 1'b0;
    wr_addr = qidx;
    wr_data = heads_r[qcpu];
    if (q_pop && q_head.cmd.kind == K_FREE) begin
      wr_en = 1'b1;
    end else if (state_r == S_CUT) begin
      wr_en   = 1'b1;
      wr_addr = r_r;
      wr_data = heads_r[cpu_r];
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= link_mem[rd_addr];
    if (wr_en) link_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        counts_r[i] <= 32'd0;
        heads_r[i]  <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_head.valid) begin
            cpu_r <= qcpu;
            case (q_head.cmd.kind)
              K_FREE: begin
                heads_r[qcpu]     <= qidx;
                counts_r[qcpu]    <= sat_add(counts_r[qcpu], 32'd1);
                out_valid         <= 1'b1;
                out_page_addr_res <= '0;
                out_status        <= ST_OK;
              end
              K_ALLOC: begin
                if (counts_r[qcpu] != 32'd0) begin
                  state_r <= S_POP;
                end else begin
                  v_r     <= '0;
                  steps_r <= '0;
                  state_r <= S_VIC;
                end
              end
              default: begin
                out_valid         <= 1'b1;
                out_page_addr_res <= '0;
                out_status        <= ST_BAD;
              end
            endcase
          end
        end
        S_POP: begin
          heads_r[cpu_r]    <= rdata_r;
          counts_r[cpu_r]   <= counts_r[cpu_r] - 32'd1;
          out_valid         <= 1'b1;
          out_page_addr_res <= page_base + (56'(heads_r[cpu_r]) << PB_LOG);
          out_status        <= ST_OK;
          state_r           <= S_IDLE;
        end
        S_VIC: begin
          if (v_r == cpu_r || counts_r[v_r] == 32'd0) begin
            if (v_r == CW'(NUM_CPUS - 1)) state_r <= S_CHK;
            else v_r <= v_r + 1'b1;
          end else begin
            h_r     <= heads_r[v_r];
            r_r     <= heads_r[v_r];
            taken_r <= TW'(1);
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          state_r <= cont ? S_WWB : S_CUT;
        end
        S_WWB: begin
          r_r     <= rdata_r;
          taken_r <= taken_r + 1'b1;
          steps_r <= steps_r + 1'b1;
          state_r <= S_WALK;
        end
        S_CUT: begin
          heads_r[v_r]    <= rdata_r;
          counts_r[v_r]   <= counts_r[v_r] - 32'(taken_r);
          heads_r[cpu_r]  <= h_r;
          counts_r[cpu_r] <= sat_add(counts_r[cpu_r], 32'(taken_r));
          if (steps_r >= TW'(STEAL_LIMIT) || v_r == CW'(NUM_CPUS - 1)) begin
            state_r <= S_CHK;
          end else begin
            v_r     <= v_r + 1'b1;
            state_r <= S_VIC;
          end
        end
        S_CHK: begin
          if (counts_r[cpu_r] != 32'd0) begin
            state_r <= S_POP;
          end else begin
            out_valid         <= 1'b1;
            out_page_addr_res <= '0;
            out_status        <= ST_OOM;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/per_cpu_page_allocator_with_steal.sv =====
// per-cpu page allocator with stealing: a free or bad free is answered from the idle state,
// a fast alloc through the pop state; a steal visits each cpu in turn, walks the links of each
// cpu robbed, cuts them over and ends with the final check.
// throughput is set by the link memory sequencer (one read and one write port); a 2-entry queue decouples start.
// synchronous active-low reset empties all lists; link memory is not cleared.
// depends on pcpa_pkg, pcpa_front, pcpa_back
module per_cpu_page_allocator_with_steal #(
  parameter int NUM_CPUS    = 8,
  parameter int STEAL_LIMIT = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_PAGES   = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [2:0]  in_cpu,
  input  logic [55:0] in_page_addr,
  output logic        out_valid,
  output logic [55:0] out_page_addr_res,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [55:0] cfg_data
);
  import pcpa_pkg::*;

  logic [55:0] page_base;
  qhead_t      q_head;
  logic        q_pop;

  pcpa_front #(
    .NUM_CPUS(NUM_CPUS), .PAGE_BYTES(PAGE_BYTES), .MAX_PAGES(MAX_PAGES)
  ) u_front (
    .clk, .rst_n, .start, .busy, .in_operation, .in_cpu, .in_page_addr,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .page_base, .q_head, .q_pop
  );

  pcpa_back #(
    .NUM_CPUS(NUM_CPUS), .STEAL_LIMIT(STEAL_LIMIT),
    .PAGE_BYTES(PAGE_BYTES), .MAX_PAGES(MAX_PAGES)
  ) u_back (
    .clk, .rst_n, .page_base, .q_head, .q_pop,
    .out_valid, .out_page_addr_res, .out_status
  );

endmodule

// ===== rtl/core/pcpa_checker.sv =====
// port-level checks for the page allocator, bound to the top level
// depends on pcpa_pkg
module pcpa_props #(
  parameter int PAGE_BYTES = 4096
) (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [55:0] out_page_addr_res,
  input logic [1:0]  out_status
);
  import pcpa_pkg::*;

  localparam int PB_LOG = $clog2(PAGE_BYTES);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OOM || out_status == ST_BAD))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_page_addr_res == 56'd0))
    else $error("error beat carries an address");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_page_addr_res[PB_LOG-1:0] == '0))
    else $error("unaligned page address");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity right after reset");

endmodule

bind per_cpu_page_allocator_with_steal pcpa_props #(.PAGE_BYTES(PAGE_BYTES)) u_pcpa_props (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_page_addr_res(out_page_addr_res), .out_status(out_status)
);
